>>> hw/rtl/cpms_pkg.sv
// Shared types and constants for the column peak and mean summary block.
package cpms_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CFG_W          = 20;
    localparam int COUNT_BITS_DEF = 20;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int MDATA_W        = 64;

    // Register index of the column length.
    localparam logic [0:0] REG_COLUMN_SAMPLES = 1'b0;
    localparam logic [CFG_W-1:0] COLUMN_SAMPLES_RESET = 20'd1;

    typedef struct packed {
        logic acc_en;     // a sample word is taken this cycle
        logic div_start;  // that sample closes the column
        logic div_step;   // one quotient bit per cycle
        logic out_load;   // move the quotients into the output register
    } cpms_cmd_t;

    typedef struct packed {
        logic col_last;   // the sample on the input closes the column
        logic div_last;   // the divider works on its final bit
    } cpms_stat_t;

endpackage

>>> hw/rtl/cpms_datapath.sv
// Accumulators, restoring dividers and result register of the summary block.
module cpms_datapath #(
    parameter int COUNT_BITS = cpms_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [cpms_pkg::SAMPLE_W-1:0]  sample,
    input  logic [cpms_pkg::CFG_W-1:0]            column_samples,
    input  cpms_pkg::cpms_cmd_t                   cmd,
    output cpms_pkg::cpms_stat_t                  stat,
    output logic signed [15:0]                    peak_low,
    output logic [14:0]                           peak_high,
    output logic signed [15:0]                    mean_low,
    output logic [14:0]                           mean_high
);
    import cpms_pkg::*;

    localparam int DW = COUNT_BITS + 15;
    localparam int SW = $clog2(DW);

    logic [COUNT_BITS-1:0]         seen_reg;
    logic [14:0]                   high_peak_reg;
    logic signed [15:0]            low_peak_reg;
    logic [DW-1:0]                 pos_sum_reg;
    logic [DW-1:0]                 neg_sum_reg;

    logic [DW-1:0]                 pos_q_reg;
    logic [DW-1:0]                 neg_q_reg;
    logic [COUNT_BITS-1:0]         pos_rem_reg;
    logic [COUNT_BITS-1:0]         neg_rem_reg;
    logic [COUNT_BITS-1:0]         divisor_reg;
    logic [SW-1:0]                 step_reg;
    logic [14:0]                   hold_high_reg;
    logic signed [15:0]            hold_low_reg;

    logic [COUNT_BITS+CFG_W-1:0]   len_ext;
    logic [COUNT_BITS-1:0]         len;
    logic [COUNT_BITS:0]           count;
    logic                          positive;
    logic [15:0]                   neg_mag;
    logic [14:0]                   high_peak_next;
    logic signed [15:0]            low_peak_next;
    logic [DW-1:0]                 pos_sum_next;
    logic [DW-1:0]                 neg_sum_next;

    logic [COUNT_BITS:0]           pos_shift;
    logic [COUNT_BITS:0]           neg_shift;
    logic                          pos_fit;
    logic                          neg_fit;
    logic [COUNT_BITS:0]           pos_diff;
    logic [COUNT_BITS:0]           neg_diff;

    // The length register is taken in its low COUNT_BITS bits; zero acts as one.
    assign len_ext = {{COUNT_BITS{1'b0}}, column_samples};
    assign len     = (len_ext[COUNT_BITS-1:0] == '0) ? COUNT_BITS'(1)
                                                     : len_ext[COUNT_BITS-1:0];
    assign count   = {1'b0, seen_reg} + (COUNT_BITS+1)'(1);

    assign stat.col_last = (count >= {1'b0, len});
    assign stat.div_last = (step_reg == '0);

    // Zero samples belong to the low side.
    assign positive = !sample[15] && (sample != '0);
    assign neg_mag  = 16'(-sample);

    always_comb
    begin
        high_peak_next = high_peak_reg;
        low_peak_next  = low_peak_reg;
        pos_sum_next   = pos_sum_reg;
        neg_sum_next   = neg_sum_reg;
        if (positive)
        begin
            if (sample[14:0] > high_peak_reg)
            begin
                high_peak_next = sample[14:0];
            end
            pos_sum_next = pos_sum_reg + DW'(sample[14:0]);
        end
        else
        begin
            if (sample < low_peak_reg)
            begin
                low_peak_next = sample;
            end
            neg_sum_next = neg_sum_reg + DW'(neg_mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            high_peak_reg <= '0;
            low_peak_reg  <= '0;
            pos_sum_reg   <= '0;
            neg_sum_reg   <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (stat.col_last)
            begin
                seen_reg      <= '0;
                high_peak_reg <= '0;
                low_peak_reg  <= '0;
                pos_sum_reg   <= '0;
                neg_sum_reg   <= '0;
            end
            else
            begin
                seen_reg      <= count[COUNT_BITS-1:0];
                high_peak_reg <= high_peak_next;
                low_peak_reg  <= low_peak_next;
                pos_sum_reg   <= pos_sum_next;
                neg_sum_reg   <= neg_sum_next;
            end
        end
    end

    // Two restoring dividers run side by side, one quotient bit per cycle.
    // The quotient shifts in behind the dividend in the same register.
    assign pos_shift = {pos_rem_reg, pos_q_reg[DW-1]};
    assign neg_shift = {neg_rem_reg, neg_q_reg[DW-1]};
    assign pos_fit   = (pos_shift >= {1'b0, divisor_reg});
    assign neg_fit   = (neg_shift >= {1'b0, divisor_reg});
    assign pos_diff  = pos_shift - {1'b0, divisor_reg};
    assign neg_diff  = neg_shift - {1'b0, divisor_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            pos_q_reg     <= pos_sum_next;
            neg_q_reg     <= neg_sum_next;
            pos_rem_reg   <= '0;
            neg_rem_reg   <= '0;
            divisor_reg   <= len;
            step_reg      <= SW'(DW - 1);
            hold_high_reg <= high_peak_next;
            hold_low_reg  <= low_peak_next;
        end
        else if (cmd.div_step)
        begin
            pos_q_reg   <= {pos_q_reg[DW-2:0], pos_fit};
            neg_q_reg   <= {neg_q_reg[DW-2:0], neg_fit};
            pos_rem_reg <= pos_fit ? pos_diff[COUNT_BITS-1:0] : pos_shift[COUNT_BITS-1:0];
            neg_rem_reg <= neg_fit ? neg_diff[COUNT_BITS-1:0] : neg_shift[COUNT_BITS-1:0];
            step_reg    <= step_reg - SW'(1);
        end
    end

    // Quotients are clamped to the field ranges when the length shrank mid-column.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            peak_high <= hold_high_reg;
            peak_low  <= hold_low_reg;
            mean_high <= (pos_q_reg > DW'(32767)) ? 15'd32767 : pos_q_reg[14:0];
            mean_low  <= (neg_q_reg > DW'(32768)) ? 16'sh8000 : 16'(-neg_q_reg[15:0]);
        end
    end

    property p_rem_below_divisor;
        @(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (pos_rem_reg < divisor_reg) && (neg_rem_reg < divisor_reg);
    endproperty
    a_rem_below_divisor: assert property (p_rem_below_divisor)
        else $error("divider remainder reached the divisor");

    property p_column_cleared;
        @(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (seen_reg == '0) && (pos_sum_reg == '0) && (neg_sum_reg == '0);
    endproperty
    a_column_cleared: assert property (p_column_cleared)
        else $error("running state not cleared after a column closed");

    property p_seen_below_len_after_step;
        @(posedge clk) disable iff (!rst_n)
        (cmd.acc_en && !stat.col_last) |=> ($past(count[COUNT_BITS-1:0]) == seen_reg);
    endproperty
    a_seen_count: assert property (p_seen_below_len_after_step)
        else $error("sample count did not advance by one");

endmodule

>>> hw/rtl/cpms_ctrl.sv
// Controller: sample intake, divider sequencing and output handshake.
module cpms_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output cpms_pkg::cpms_cmd_t   cmd,
    input  cpms_pkg::cpms_stat_t  stat
);
    import cpms_pkg::*;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign s_tready = (state_reg == ST_ACC);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd.acc_en    = s_tvalid && s_tready;
        cmd.div_start = s_tvalid && s_tready && stat.col_last;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.out_load  = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

        state_next = state_reg;
        case (state_reg)
            ST_ACC:
            begin
                if (cmd.div_start)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (cmd.out_load)
                begin
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    property p_load_when_free;
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready);
    endproperty
    a_load_when_free: assert property (p_load_when_free)
        else $error("result word overwritten before it was taken");

    property p_stall_after_close;
        @(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !s_tready && cmd.div_step;
    endproperty
    a_stall_after_close: assert property (p_stall_after_close)
        else $error("intake not stalled while the divider runs");

    property p_result_after_load;
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid && s_tready;
    endproperty
    a_result_after_load: assert property (p_result_after_load)
        else $error("result word missing after load");

endmodule

>>> hw/rtl/column_peak_mean_summary.sv
// After the column's last sample word is taken, the bit-serial divider runs, the quotients
// load into the output register and the summary word shows on m_tvalid.
// Throughput: one sample word per cycle inside a column; each column closure stalls the
// input while the divider runs, longer while an earlier summary word waits.
// Reset (rst_n, asynchronous, active low) clears the running sums, peaks and count,
// sets the column length to one and empties the output register.
module column_peak_mean_summary #(
    parameter int COUNT_BITS = cpms_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] sample
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] peak_low, [30:16] peak_high, [46:31] mean_low, [61:47] mean_high, [63:62] zero
    output logic [cpms_pkg::MDATA_W-1:0]    m_tdata,
    // Register port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cpms_pkg::PADDR_W-1:0]    paddr,
    input  logic [cpms_pkg::PDATA_W-1:0]    pwdata,
    output logic [cpms_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);
    import cpms_pkg::*;

    logic [CFG_W-1:0]   column_samples_reg;
    logic               reg_hit;
    cpms_cmd_t          cmd;
    cpms_stat_t         stat;
    logic signed [15:0] peak_low;
    logic [14:0]        peak_high;
    logic signed [15:0] mean_low;
    logic [14:0]        mean_high;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_COLUMN_SAMPLES);
    assign prdata  = reg_hit ? PDATA_W'(column_samples_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_samples_reg <= COLUMN_SAMPLES_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            column_samples_reg <= pwdata[CFG_W-1:0];
        end
    end

    cpms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    cpms_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample         (s_tdata),
        .column_samples (column_samples_reg),
        .cmd            (cmd),
        .stat           (stat),
        .peak_low       (peak_low),
        .peak_high      (peak_high),
        .mean_low       (mean_low),
        .mean_high      (mean_high)
    );

    assign m_tdata = {2'b00, mean_high, mean_low, peak_high, peak_low};

endmodule

>>> verif/column_peak_mean_summary_chk.sv
// Checker for column_peak_mean_summary: predicts column summaries from the channels and compares.
`timescale 1ns / 100ps

module column_peak_mean_summary_chk
    import cpms_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [15:0]        s_tdata,    // [15:0] sample
    input  logic               m_tvalid,
    input  logic               m_tready,
    // [15:0] peak_low, [30:16] peak_high, [46:31] mean_low, [61:47] mean_high, [63:62] zero
    input  logic [MDATA_W-1:0] m_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic [PDATA_W-1:0] prdata,
    input  logic               pready,
    output int                 mismatch_count,
    output int                 summaries_pending
);

    // Same layout as m_tdata[61:0], first member in the top bits.
    typedef struct packed {
        logic [14:0] mean_high;
        logic [15:0] mean_low;
        logic [14:0] peak_high;
        logic [15:0] peak_low;
    } summary_t;

    summary_t           summary_q[$];
    logic [CFG_W-1:0]   column_len;
    logic [14:0]        run_peak_high;
    logic signed [15:0] run_peak_low;
    logic [34:0]        pos_sum;
    logic [35:0]        neg_mag;
    logic [CFG_W-1:0]   run_count;
    int                 errors;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s: got 0x%0h, wanted 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic summary_t close_column(input logic [CFG_W-1:0] eff_len);
        longint unsigned mh;
        longint unsigned ml;
        summary_t        r;
        mh = pos_sum / eff_len;
        if (mh > 32767)
            mh = 32767;
        ml = neg_mag / eff_len;
        if (ml > 32768)
            ml = 32768;
        r.peak_low  = run_peak_low;
        r.peak_high = run_peak_high;
        r.mean_low  = 16'(64'd0 - ml);
        r.mean_high = mh[14:0];
        return r;
    endfunction

    task automatic absorb_sample(input logic [15:0] word);
        logic signed [15:0] s;
        int                 si;
        logic [CFG_W-1:0]   eff_len;
        logic [CFG_W:0]     next_count;
        s = word;
        si = s;
        // A length of zero behaves as one.
        eff_len = (column_len == 0) ? CFG_W'(1) : column_len;
        if (s > 0) begin
            if (s[14:0] > run_peak_high)
                run_peak_high = s[14:0];
            pos_sum = pos_sum + 35'(si);
        end
        else begin
            if (s < run_peak_low)
                run_peak_low = s;
            neg_mag = neg_mag + 36'(-si);
        end
        next_count = {1'b0, run_count} + 1'b1;
        // A count already at or past a lowered length closes the column here.
        if (next_count < eff_len)
            run_count = next_count[CFG_W-1:0];
        else begin
            summary_q.push_back(close_column(eff_len));
            run_peak_high = '0;
            run_peak_low = '0;
            pos_sum = '0;
            neg_mag = '0;
            run_count = '0;
        end
    endtask

    task automatic check_summary(input logic [MDATA_W-1:0] word);
        summary_t got;
        summary_t want;
        got = summary_t'(word[61:0]);
        if (summary_q.size() == 0)
            report_mismatch("summary word with no column pending", word, 64'd0);
        else begin
            want = summary_q.pop_front();
            if (got.peak_low != want.peak_low)
                report_mismatch("peak_low", 64'(got.peak_low), 64'(want.peak_low));
            if (got.peak_high != want.peak_high)
                report_mismatch("peak_high", 64'(got.peak_high), 64'(want.peak_high));
            if (got.mean_low != want.mean_low)
                report_mismatch("mean_low", 64'(got.mean_low), 64'(want.mean_low));
            if (got.mean_high != want.mean_high)
                report_mismatch("mean_high", 64'(got.mean_high), 64'(want.mean_high));
            if (word[63:62] != 2'b00)
                report_mismatch("padding bits", 64'(word[63:62]), 64'd0);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            summary_q.delete();
            column_len = COLUMN_SAMPLES_RESET;
            run_peak_high = '0;
            run_peak_low = '0;
            pos_sum = '0;
            neg_mag = '0;
            run_count = '0;
            errors = 0;
            mismatch_count <= 0;
            summaries_pending <= 0;
        end
        else begin
            if (s_tvalid && s_tready)
                absorb_sample(s_tdata);
            if (m_tvalid && m_tready)
                check_summary(m_tdata);
            if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_COLUMN_SAMPLES) begin
                if (pwrite)
                    column_len = pwdata[CFG_W-1:0];
                else if (prdata != PDATA_W'(column_len))
                    report_mismatch("column_samples readback", 64'(prdata), 64'(column_len));
            end
            mismatch_count <= errors;
            summaries_pending <= summary_q.size();
        end
    end

endmodule

>>> verif/column_peak_mean_summary_tb.sv
// Testbench top for column_peak_mean_summary: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module column_peak_mean_summary_tb;
    import cpms_pkg::*;

    localparam int DIV_LATENCY = COUNT_BITS_DEF + 16;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_WORDS = 610;
    localparam logic [PADDR_W-1:0] ADDR_COLUMN_SAMPLES = {REG_COLUMN_SAMPLES, 2'b00};
    // Index one holds no register; writes there must change nothing.
    localparam logic [PADDR_W-1:0] ADDR_SPARE = {~REG_COLUMN_SAMPLES, 2'b00};

    logic               clk;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [15:0]        s_tdata = '0;      // [15:0] sample
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // [15:0] peak_low, [30:16] peak_high, [46:31] mean_low, [61:47] mean_high, [63:62] zero
    logic [MDATA_W-1:0] m_tdata;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int mismatch_count;
    int summaries_pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;

    column_peak_mean_summary dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    column_peak_mean_summary_chk chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .mismatch_count    (mismatch_count),
        .summaries_pending (summaries_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("column_peak_mean_summary verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_word(input logic [15:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending, let every pending summary out, then give the divider time to go quiet.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (summaries_pending != 0)
            @(posedge clk);
        repeat (DIV_LATENCY + 4) @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_column_length(input logic [PDATA_W-1:0] value);
        settle_block();
        apb_access(1'b1, ADDR_COLUMN_SAMPLES, value);
        apb_access(1'b0, ADDR_COLUMN_SAMPLES, '0);
    endtask

    // bias: 4 keeps a batch positive, 5 keeps it non-positive, anything else mixes.
    function automatic logic [15:0] pick_sample(input int bias);
        int kind;
        kind = $urandom_range(0, 99);
        if (bias == 4)
            return (kind < 10) ? 16'h7FFF : 16'($urandom_range(1, 32767));
        if (bias == 5) begin
            if (kind < 10)
                return 16'h8000;
            if (kind < 20)
                return 16'h0000;
            return 16'(-int'($urandom_range(0, 32768)));
        end
        if (kind < 8)
            return 16'h8000;
        if (kind < 16)
            return 16'h7FFF;
        if (kind < 24)
            return 16'h0000;
        if (kind < 34)
            return 16'(int'($urandom_range(0, 8)) - 4);
        return 16'($urandom());
    endfunction

    task automatic random_phase(input int words);
        int               sent;
        int               batch;
        int               bias;
        int               len_pick;
        logic [PDATA_W-1:0] len;
        sent = 0;
        while (sent < words) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 55)
                len = $urandom_range(1, 8);
            else if (len_pick < 80)
                len = $urandom_range(9, 64);
            else if (len_pick < 92)
                len = $urandom_range(65, 400);
            else if (len_pick < 96)
                len = 0;
            else
                len = $urandom_range(1, 3);
            // Bits above the register width must be dropped by the block.
            len = len | ($urandom() & 32'hFFF0_0000);
            set_column_length(len);
            batch = $urandom_range(1, 150);
            if (batch > words - sent)
                batch = words - sent;
            bias = $urandom_range(0, 5);
            repeat (batch) send_word(pick_sample(bias));
            sent += batch;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Length one out of reset: every word closes its own column.
        send_word(16'h8000);
        send_word(16'h7FFF);
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0001);
        send_word(16'h5555);
        send_word(16'hAAAA);

        // Low bits all zero: a zero length acts as one.
        set_column_length(32'hFFF0_0000);
        send_word(16'h0064);
        send_word(16'hFF9C);

        // All-zero, all-positive and all-negative columns of three.
        set_column_length(32'd3);
        repeat (3) send_word(16'h0000);
        send_word(16'h0005);
        send_word(16'h0006);
        send_word(16'h0007);
        send_word(16'hFFFB);
        send_word(16'hFFF9);
        send_word(16'hFFFF);

        // Longest column, then cut short: the means must clamp.
        set_column_length(32'h000F_FFFF);
        repeat (2) begin
            send_word(16'h7FFF);
            send_word(16'h8000);
        end
        send_word(16'h7FFF);
        settle_block();
        apb_access(1'b1, ADDR_SPARE, 32'd2);
        set_column_length(32'd2);
        send_word(16'h8000);

        send_idle_pct = 29;
        recv_idle_pct = 57;
        random_phase(PHASE_WORDS);
        send_idle_pct = 57;
        recv_idle_pct = 29;
        random_phase(PHASE_WORDS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_WORDS);

        settle_block();
        if (mismatch_count == 0 && summaries_pending == 0)
            $display("column_peak_mean_summary verification clean");
        else
            $display("column_peak_mean_summary verification failed");
        $finish;
    end

endmodule
